// ===== src/cfb_pkg.sv =====
package cfb_pkg;

  localparam int SHORT_BODY  = 6;
  localparam int LONG_BODY   = 11;
  localparam int BODY_MAX    = LONG_BODY;
  localparam int IDX_W       = $clog2(BODY_MAX + 2);
  localparam int QUEUE_DEPTH = 2;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  localparam logic KIND_SHORT = 1'b0;
  localparam logic KIND_LONG  = 1'b1;

  typedef struct packed {
    logic        kind;
    logic [7:0]  header;
    logic [7:0]  command;
    logic [15:0] address;
    logic [15:0] count_value;
    logic [7:0]  length_byte;
    logic [31:0] payload;
  } cfb_req_t;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       last_byte;
  } cfb_res_t;

  typedef struct packed {
    logic                     kind;
    logic [BODY_MAX-1:0][7:0] body;
  } cfb_desc_t;

  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] data);
    logic [15:0] c;
    c = crc_in ^ {8'h00, data};
    for (int b = 0; b < 8; b++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

// ===== src/command_frame_builder_crc16_core.sv =====
// Path: input stage register, the queue, then the serializer's output register.
// Throughput: one byte per cycle during a frame of 8 (short) or 13 (long) bytes;
// frames follow with no gap while the queue holds the next one.
// Reset: synchronous, active low; clears the input stage, queue and serializer.
// The receiver cannot stall: each out_valid strobe is one byte transfer.
module command_frame_builder_crc16_core #(
  parameter int QDEPTH = cfb_pkg::QUEUE_DEPTH
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  cfb_pkg::cfb_req_t in_req,
  output logic              out_valid,
  output cfb_pkg::cfb_res_t out_res
);
  import cfb_pkg::*;

  logic      push;
  cfb_desc_t push_desc;
  logic      q_full;
  logic      pop;
  logic      q_nempty;
  cfb_desc_t q_desc;

  cfb_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_req    (in_req),
    .push      (push),
    .push_desc (push_desc),
    .q_full    (q_full)
  );

  cfb_queue #(
    .DEPTH (QDEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_desc (push_desc),
    .full      (q_full),
    .pop       (pop),
    .nempty    (q_nempty),
    .pop_desc  (q_desc)
  );

  cfb_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_nempty  (q_nempty),
    .q_desc    (q_desc),
    .pop       (pop),
    .out_valid (out_valid),
    .out_res   (out_res)
  );

endmodule

// ===== src/cfb_front.sv =====
module cfb_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  cfb_pkg::cfb_req_t  in_req,
  output logic               push,
  output cfb_pkg::cfb_desc_t push_desc,
  input  logic               q_full
);
  import cfb_pkg::*;

  logic      valid_r, valid_nxt;
  cfb_desc_t desc_r, desc_nxt;
  logic      accept;

  assign busy      = valid_r & q_full;
  assign accept    = start & ~busy;
  assign push      = valid_r & ~q_full;
  assign push_desc = desc_r;

  always_comb begin
    desc_nxt         = '0;
    desc_nxt.kind    = in_req.kind;
    desc_nxt.body[0] = in_req.header;
    desc_nxt.body[1] = in_req.command;
    desc_nxt.body[2] = in_req.address[15:8];
    desc_nxt.body[3] = in_req.address[7:0];
    if (in_req.kind == KIND_LONG) begin
      desc_nxt.body[4]  = in_req.count_value[15:8];
      desc_nxt.body[5]  = in_req.count_value[7:0];
      desc_nxt.body[6]  = in_req.length_byte;
      desc_nxt.body[7]  = in_req.payload[15:8];
      desc_nxt.body[8]  = in_req.payload[7:0];
      desc_nxt.body[9]  = in_req.payload[31:24];
      desc_nxt.body[10] = in_req.payload[23:16];
    end else begin
      desc_nxt.body[4] = in_req.payload[15:8];
      desc_nxt.body[5] = in_req.payload[7:0];
    end
  end

  always_comb begin
    valid_nxt = valid_r;
    if (accept) begin
      valid_nxt = 1'b1;
    end else if (push) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      desc_r <= desc_nxt;
    end
  end

endmodule

// ===== src/cfb_queue.sv =====
module cfb_queue #(
  parameter int DEPTH = cfb_pkg::QUEUE_DEPTH
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  cfb_pkg::cfb_desc_t push_desc,
  output logic               full,
  input  logic               pop,
  output logic               nempty,
  output cfb_pkg::cfb_desc_t pop_desc
);
  import cfb_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  cfb_desc_t         mem [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;

  assign full     = (cnt_r == CNT_W'(DEPTH));
  assign nempty   = (cnt_r != '0);
  assign pop_desc = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_desc;
    end
  end

endmodule

// ===== src/cfb_back.sv =====
module cfb_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_nempty,
  input  cfb_pkg::cfb_desc_t q_desc,
  output logic               pop,
  output logic               out_valid,
  output cfb_pkg::cfb_res_t  out_res
);
  import cfb_pkg::*;

  logic             active_r, active_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic [15:0]      crc_r, crc_nxt;
  cfb_desc_t        desc_r;
  logic             oval_r, oval_nxt;
  cfb_res_t         ores_r, ores_nxt;
  logic [IDX_W-1:0] body_len;
  logic             in_body;
  logic             at_lo;
  logic             at_last;
  logic [7:0]       body_byte;

  assign body_len  = (desc_r.kind == KIND_LONG) ? IDX_W'(LONG_BODY) : IDX_W'(SHORT_BODY);
  assign in_body   = idx_r < body_len;
  assign at_lo     = idx_r == body_len;
  assign at_last   = idx_r == body_len + 1'b1;
  assign pop       = (~active_r | at_last) & q_nempty;
  assign out_valid = oval_r;
  assign out_res   = ores_r;

  always_comb begin
    body_byte = 8'h00;
    for (int i = 0; i < BODY_MAX; i++) begin
      if (idx_r == IDX_W'(i)) begin
        body_byte = desc_r.body[i];
      end
    end
  end

  always_comb begin
    active_nxt = active_r;
    idx_nxt    = idx_r;
    crc_nxt    = crc_r;
    oval_nxt   = 1'b0;
    ores_nxt   = '0;
    if (active_r) begin
      oval_nxt = 1'b1;
      idx_nxt  = idx_r + 1'b1;
      if (in_body) begin
        ores_nxt.frame_byte = body_byte;
        crc_nxt             = crc_byte(crc_r, body_byte);
      end else if (at_lo) begin
        ores_nxt.frame_byte = crc_r[7:0];
      end else begin
        ores_nxt.frame_byte = crc_r[15:8];
        ores_nxt.last_byte  = 1'b1;
        active_nxt          = 1'b0;
      end
    end
    if (pop) begin
      active_nxt = 1'b1;
      idx_nxt    = '0;
      crc_nxt    = CRC_INIT;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      oval_r   <= 1'b0;
    end else begin
      active_r <= active_nxt;
      oval_r   <= oval_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r  <= idx_nxt;
    crc_r  <= crc_nxt;
    ores_r <= ores_nxt;
    if (pop) begin
      desc_r <= q_desc;
    end
  end

endmodule
